@@ sv/lps_pkg.sv @@
// lps_pkg: shared constants and codes for the led pattern sequencer
package lps_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int HOLD_WIDTH  = 16;

    localparam int OP_W        = 2;
    localparam int INDEX_W     = 4;
    localparam int RGB_W       = 3;
    localparam int HOLD_IN_W   = 16;
    localparam int LENGTH_W    = 5;
    localparam int PASS_W      = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(1);
    localparam logic [PASS_W-1:0]   PASS_RESET   = PASS_W'(1);

    // bit positions inside a colour code
    localparam int RED_POS   = 2;
    localparam int GREEN_POS = 1;
    localparam int BLUE_POS  = 0;

    localparam logic [RGB_W-1:0] LED_OFF = '0;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_LOAD  = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LENGTH = 4'd0,
        CFG_PASS_COUNT     = 4'd1
    } cfg_index_t;

endpackage

@@ sv/lps_if.sv @@
// lps_if: handshake channels for items, results and configuration writes
interface lps_item_if;
    logic                          valid;
    logic                          ready;
    logic [lps_pkg::OP_W-1:0]      operation;
    logic [lps_pkg::INDEX_W-1:0]   entry_index;
    logic [lps_pkg::RGB_W-1:0]     entry_rgb;
    logic [lps_pkg::HOLD_IN_W-1:0] entry_hold;

    modport source (output valid, operation, entry_index, entry_rgb, entry_hold,
                    input ready);
    modport sink   (input valid, operation, entry_index, entry_rgb, entry_hold,
                    output ready);
endinterface

interface lps_result_if;
    logic valid;
    logic ready;
    logic led_red;
    logic led_green;
    logic led_blue;
    logic busy_res;

    modport source (output valid, led_red, led_green, led_blue, busy_res,
                    input ready);
    modport sink   (input valid, led_red, led_green, led_blue, busy_res,
                    output ready);
endinterface

interface lps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lps_pkg::CFG_INDEX_W-1:0] index;
    logic [lps_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/led_pattern_sequencer.sv @@
// led_pattern_sequencer: plays a stored rgb pattern from a loadable table
//
// channels
//   item   : one beat per operation (tick, start, load of a table entry)
//   result : one beat per item, the led drive and busy flag after that item
//   cfg    : register writes (pattern length, pass count), always ready
// timing
//   the result of an item is offered in the cycle after its beat is taken and
//   one item can be taken every cycle while the result side is not stalled;
//   the table memory is read every cycle at the entry the next step would
//   land on, so a step never waits on the registered read of that memory
// stalls
//   the result register holds its beat while the receiver is not ready and
//   item ready follows result ready, so a stalled sink stops the input side
//   only while a result is actually waiting
// reset
//   rst_n clears the player (stopped, led off) and loads length 1 and one
//   pass; the table has no clearing pass and its entries are undefined
//   until loaded
module led_pattern_sequencer #(
    parameter int MAX_ENTRIES = lps_pkg::MAX_ENTRIES,
    parameter int HOLD_WIDTH  = lps_pkg::HOLD_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    lps_item_if.sink      item,
    lps_result_if.source  result,
    lps_cfg_if.sink       cfg
);

    // position must hold the table size itself (armed state after start)
    localparam int PW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int DW = lps_pkg::RGB_W + HOLD_WIDTH;

    // configuration registers
    logic [lps_pkg::LENGTH_W-1:0] pattern_length_reg, pattern_length_next;
    logic [lps_pkg::PASS_W-1:0]   pass_count_reg, pass_count_next;

    // player state
    logic [PW-1:0]                position_reg, position_next;
    logic [HOLD_WIDTH-1:0]        hold_left_reg, hold_left_next;
    logic [lps_pkg::PASS_W-1:0]   passes_left_reg, passes_left_next;
    logic                         playing_reg, playing_next;
    logic [lps_pkg::RGB_W-1:0]    led_colour_reg, led_colour_next;

    // result register
    logic                         out_valid_reg;
    logic [lps_pkg::RGB_W-1:0]    out_colour_reg;
    logic                         out_busy_reg;

    // table ports
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [DW-1:0]                wr_data;
    logic [AW-1:0]                rd_addr;
    logic [DW-1:0]                rd_data;

    logic                         item_fire;
    logic [PW-1:0]                len_cur;
    logic [PW-1:0]                len_nxt;
    logic [PW-1:0]                step_target;
    logic                         step_fwd;

    // length in use, saturated to the table size
    function automatic logic [PW-1:0] clip_len(input logic [lps_pkg::LENGTH_W-1:0] l);
        if (32'(l) > MAX_ENTRIES)
        begin
            return PW'(MAX_ENTRIES);
        end
        return PW'(l);
    endfunction

    // entry a step lands on: next one, or wrap to the first
    function automatic logic [PW-1:0] succ(input logic [PW-1:0] pos,
                                           input logic [PW-1:0] len);
        logic [PW:0] p1;
        p1 = {1'b0, pos} + (PW+1)'(1);
        if ((len != '0) && (p1 < {1'b0, len}))
        begin
            return p1[PW-1:0];
        end
        return '0;
    endfunction

    assign item_fire   = item.valid && item.ready;
    assign item.ready  = !out_valid_reg || result.ready;
    assign cfg.ready   = 1'b1;

    assign len_cur     = clip_len(pattern_length_reg);
    assign len_nxt     = clip_len(pattern_length_next);
    assign step_target = succ(position_reg, len_cur);
    assign step_fwd    = (len_cur != '0) &&
                         (({1'b0, position_reg} + (PW+1)'(1)) < {1'b0, len_cur});

    // configuration writes
    always_comb
    begin
        pattern_length_next = pattern_length_reg;
        pass_count_next     = pass_count_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                lps_pkg::CFG_PATTERN_LENGTH:
                begin
                    pattern_length_next = cfg.data[lps_pkg::LENGTH_W-1:0];
                end
                lps_pkg::CFG_PASS_COUNT:
                begin
                    pass_count_next = cfg.data[lps_pkg::PASS_W-1:0];
                end
                default:
                begin
                    pattern_length_next = pattern_length_reg;
                end
            endcase
        end
    end

    // table loads, out-of-range slots dropped
    assign wr_en   = item_fire && (item.operation == lps_pkg::OP_LOAD) &&
                     (32'(item.entry_index) < MAX_ENTRIES);
    assign wr_addr = AW'(item.entry_index);
    assign wr_data = {item.entry_rgb, HOLD_WIDTH'(item.entry_hold)};

    // player update
    always_comb
    begin
        position_next    = position_reg;
        hold_left_next   = hold_left_reg;
        passes_left_next = passes_left_reg;
        playing_next     = playing_reg;
        led_colour_next  = led_colour_reg;
        if (item_fire)
        begin
            case (item.operation)
                lps_pkg::OP_TICK:
                begin
                    if (playing_reg)
                    begin
                        if (hold_left_reg != '0)
                        begin
                            hold_left_next = hold_left_reg - HOLD_WIDTH'(1);
                        end
                        else if (step_fwd ||
                                 ((passes_left_reg != '0) && (len_cur != '0)))
                        begin
                            // prefetched entry is the one at step_target
                            position_next   = step_target;
                            if (!step_fwd)
                            begin
                                passes_left_next = passes_left_reg - lps_pkg::PASS_W'(1);
                            end
                            led_colour_next = rd_data[DW-1 -: lps_pkg::RGB_W];
                            hold_left_next  = rd_data[HOLD_WIDTH-1:0];
                        end
                        else
                        begin
                            position_next   = '0;
                            led_colour_next = lps_pkg::LED_OFF;
                            playing_next    = 1'b0;
                        end
                    end
                end
                lps_pkg::OP_START:
                begin
                    hold_left_next   = '0;
                    passes_left_next = pass_count_reg;
                    if (len_cur == '0)
                    begin
                        position_next   = '0;
                        playing_next    = 1'b0;
                        led_colour_next = lps_pkg::LED_OFF;
                    end
                    else
                    begin
                        position_next = len_cur;
                        playing_next  = 1'b1;
                    end
                end
                default:
                begin
                    playing_next = playing_reg;
                end
            endcase
        end
    end

    // read ahead at the entry the next step from the new state lands on
    assign rd_addr = AW'(succ(position_next, len_nxt));

    lps_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW),
        .DW    (DW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= lps_pkg::LENGTH_RESET;
            pass_count_reg     <= lps_pkg::PASS_RESET;
            position_reg       <= '0;
            hold_left_reg      <= '0;
            passes_left_reg    <= '0;
            playing_reg        <= 1'b0;
            led_colour_reg     <= lps_pkg::LED_OFF;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            pattern_length_reg <= pattern_length_next;
            pass_count_reg     <= pass_count_next;
            position_reg       <= position_next;
            hold_left_reg      <= hold_left_next;
            passes_left_reg    <= passes_left_next;
            playing_reg        <= playing_next;
            led_colour_reg     <= led_colour_next;
            if (item_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            out_colour_reg <= led_colour_next;
            out_busy_reg   <= playing_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.led_red   = out_colour_reg[lps_pkg::RED_POS];
    assign result.led_green = out_colour_reg[lps_pkg::GREEN_POS];
    assign result.led_blue  = out_colour_reg[lps_pkg::BLUE_POS];
    assign result.busy_res  = out_busy_reg;

endmodule

@@ sv/lps_table.sv @@
// lps_table: pattern table memory, one write and one registered read port
module lps_table #(
    parameter int DEPTH = lps_pkg::MAX_ENTRIES,
    parameter int AW    = 4,
    parameter int DW    = 19
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-through on a same-address collision
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/lps_checker.sv @@
// lps_checker: port-level checks on the led pattern sequencer, bound to the top
module lps_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic led_red,
    input logic led_green,
    input logic led_blue,
    input logic busy_res
);

    // a waiting result beat is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result beat dropped while stalled");

    // every taken item gives a result in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no result after an accepted item");

    // an empty result register never blocks the input side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result waiting");

    // a stopped player always shows the led off
    a_off_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |-> (!led_red && !led_green && !led_blue))
        else $error("led lit while not playing");

endmodule

bind led_pattern_sequencer lps_checker u_lps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .led_red   (result.led_red),
    .led_green (result.led_green),
    .led_blue  (result.led_blue),
    .busy_res  (result.busy_res)
);

@@ sim/tb_led_pattern_sequencer.sv @@
// tb_led_pattern_sequencer: self-checking regression for the led pattern sequencer
`timescale 1ns / 100ps

module tb_led_pattern_sequencer;

    // operation code the block must ignore
    localparam logic [lps_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    localparam int NUM_PHASES     = 20;
    localparam int PHASE_ITEMS    = 64;
    localparam int HOLD_OFF_BEATS = 300;
    localparam int DRAIN_LIMIT    = 2000;

    // led drive and busy flag carried by one result beat
    typedef struct packed {
        logic red;
        logic green;
        logic blue;
        logic busy;
    } led_drive_t;

    // mirrors the player state and queues the led drive each item should give
    class led_pattern_scoreboard;
        logic [lps_pkg::LENGTH_W-1:0]   length_reg;
        logic [lps_pkg::PASS_W-1:0]     pass_reg;
        logic [lps_pkg::RGB_W-1:0]      colour_tab [lps_pkg::MAX_ENTRIES];
        logic [lps_pkg::HOLD_WIDTH-1:0] hold_tab [lps_pkg::MAX_ENTRIES];
        logic [lps_pkg::LENGTH_W-1:0]   position;
        logic [lps_pkg::HOLD_WIDTH-1:0] hold_left;
        logic [lps_pkg::PASS_W-1:0]     passes_left;
        logic                           playing;
        logic [lps_pkg::RGB_W-1:0]      led;
        led_drive_t                     led_drive_q [$];
        int unsigned                    mismatches;

        function new();
            length_reg  = lps_pkg::LENGTH_RESET;
            pass_reg    = lps_pkg::PASS_RESET;
            position    = '0;
            hold_left   = '0;
            passes_left = '0;
            playing     = 1'b0;
            led         = lps_pkg::LED_OFF;
            mismatches  = 0;
        endfunction

        function void write_register(lps_pkg::cfg_index_t idx,
                                     logic [lps_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lps_pkg::CFG_PATTERN_LENGTH: length_reg = data[lps_pkg::LENGTH_W-1:0];
                lps_pkg::CFG_PASS_COUNT:     pass_reg   = data[lps_pkg::PASS_W-1:0];
                default: ;
            endcase
        endfunction

        // lengths beyond the table are clipped to its size
        function int used_length();
            return (int'(length_reg) > lps_pkg::MAX_ENTRIES) ?
                   lps_pkg::MAX_ENTRIES : int'(length_reg);
        endfunction

        function void note_item(logic [lps_pkg::OP_W-1:0] op,
                                logic [lps_pkg::INDEX_W-1:0] idx,
                                logic [lps_pkg::RGB_W-1:0] rgb,
                                logic [lps_pkg::HOLD_IN_W-1:0] hold);
            int         len;
            led_drive_t want;
            case (op)
                lps_pkg::OP_TICK:
                begin
                    if (playing)
                    begin
                        len = used_length();
                        if (hold_left != 0)
                            hold_left = hold_left - 1'b1;
                        else if (len != 0 && int'(position) + 1 < len)
                        begin
                            position  = position + 1'b1;
                            led       = colour_tab[position[lps_pkg::INDEX_W-1:0]];
                            hold_left = hold_tab[position[lps_pkg::INDEX_W-1:0]];
                        end
                        else if (passes_left != 0 && len != 0)
                        begin
                            // wrap to the first entry, one pass used up
                            position    = '0;
                            passes_left = passes_left - 1'b1;
                            led         = colour_tab[0];
                            hold_left   = hold_tab[0];
                        end
                        else
                        begin
                            position = '0;
                            led      = lps_pkg::LED_OFF;
                            playing  = 1'b0;
                        end
                    end
                end
                lps_pkg::OP_START:
                begin
                    len         = used_length();
                    hold_left   = '0;
                    passes_left = pass_reg;
                    if (len == 0)
                    begin
                        position = '0;
                        playing  = 1'b0;
                        led      = lps_pkg::LED_OFF;
                    end
                    else
                    begin
                        position = lps_pkg::LENGTH_W'(len);
                        playing  = 1'b1;
                    end
                end
                lps_pkg::OP_LOAD:
                begin
                    colour_tab[idx] = rgb;
                    hold_tab[idx]   = hold[lps_pkg::HOLD_WIDTH-1:0];
                end
                default: ;
            endcase
            want.red   = led[lps_pkg::RED_POS];
            want.green = led[lps_pkg::GREEN_POS];
            want.blue  = led[lps_pkg::BLUE_POS];
            want.busy  = playing;
            led_drive_q.push_back(want);
        endfunction

        function void compare_field(string name, logic want, logic got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected %0b actual %0b",
                         $time, name, want, got);
            end
        endfunction

        function void check_beat(led_drive_t got);
            led_drive_t want;
            if (led_drive_q.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: unexpected result beat, expected none actual %b",
                         $time, got);
                return;
            end
            want = led_drive_q.pop_front();
            compare_field("led_red",   want.red,   got.red);
            compare_field("led_green", want.green, got.green);
            compare_field("led_blue",  want.blue,  got.blue);
            compare_field("busy_res",  want.busy,  got.busy);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    // steady: no idling on either side; hold_off_req: sink stalls for a long stretch
    bit steady;
    bit hold_off_req;

    lps_item_if   item_ch ();
    lps_result_if result_ch ();
    lps_cfg_if    cfg_ch ();

    led_pattern_scoreboard sb = new();

    led_pattern_sequencer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // offer one item beat, with an occasional gap in front of it
    task automatic send_item(logic [lps_pkg::OP_W-1:0] op,
                             logic [lps_pkg::INDEX_W-1:0] idx,
                             logic [lps_pkg::RGB_W-1:0] rgb,
                             logic [lps_pkg::HOLD_IN_W-1:0] hold);
        int gap;
        @(negedge clk);
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            gap = $urandom_range(1, 3);
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid       = 1'b1;
        item_ch.operation   = op;
        item_ch.entry_index = idx;
        item_ch.entry_rgb   = rgb;
        item_ch.entry_hold  = hold;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_item(op, idx, rgb, hold);
    endtask

    // register write beat; the caller drops valid afterwards
    task automatic write_register(lps_pkg::cfg_index_t idx,
                                  logic [lps_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.write_register(idx, data);
    endtask

    // stop offering items, let every result come back, then set both registers
    task automatic reconfigure(logic [lps_pkg::LENGTH_W-1:0] len,
                               logic [lps_pkg::PASS_W-1:0] passes);
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (sb.led_drive_q.size() != 0)
            @(posedge clk);
        // margin before the register writes
        repeat (3) @(posedge clk);
        write_register(lps_pkg::CFG_PATTERN_LENGTH, lps_pkg::CFG_DATA_W'(len));
        write_register(lps_pkg::CFG_PASS_COUNT, lps_pkg::CFG_DATA_W'(passes));
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        repeat (2) @(posedge clk);
    endtask

    // result sink: random stalls, a quiet stretch, and one long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n)
            begin
                if (hold_off_req)
                begin
                    result_ch.ready = 1'b0;
                    repeat (HOLD_OFF_BEATS - 1) @(negedge clk);
                    hold_off_req = 1'b0;
                end
                else
                    result_ch.ready = steady || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // results are taken at the rising edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_beat({result_ch.led_red, result_ch.led_green,
                               result_ch.led_blue, result_ch.busy_res});
        end
    end

    // hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("led_pattern_sequencer regression: fail");
        $finish;
    end

    initial
    begin
        int                             waited;
        int                             pick;
        int                             len_pick;
        int                             pass_pick;
        logic [lps_pkg::LENGTH_W-1:0]   len;
        logic [lps_pkg::PASS_W-1:0]     passes;
        logic [lps_pkg::OP_W-1:0]       op;
        logic [lps_pkg::INDEX_W-1:0]    idx;
        logic [lps_pkg::RGB_W-1:0]      rgb;
        logic [lps_pkg::HOLD_IN_W-1:0]  hold;

        rst_n               = 1'b0;
        steady              = 1'b0;
        hold_off_req        = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.operation   = lps_pkg::OP_TICK;
        item_ch.entry_index = '0;
        item_ch.entry_rgb   = '0;
        item_ch.entry_hold  = '0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = lps_pkg::CFG_PATTERN_LENGTH;
        cfg_ch.data         = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, run at the reset settings of length 1 and one pass
        // tick while stopped, then the unused operation code with every bit set
        send_item(lps_pkg::OP_TICK, '0, '0, '0);
        send_item(OP_SPARE, '1, '1, '1);
        // fill the whole table so no start can ever read an unwritten entry;
        // slot 0 gets the longest hold
        for (int i = 0; i < lps_pkg::MAX_ENTRIES; i++)
            send_item(lps_pkg::OP_LOAD, lps_pkg::INDEX_W'(i), lps_pkg::RGB_W'(7 - (i % 8)),
                      (i == 0) ? '1 : lps_pkg::HOLD_IN_W'(i % 3));
        send_item(lps_pkg::OP_START, '0, '0, '0);
        send_item(lps_pkg::OP_TICK, '0, '0, '0);   // first tick wraps and shows slot 0
        send_item(lps_pkg::OP_TICK, '0, '0, '0);   // counts down the long hold
        send_item(lps_pkg::OP_LOAD, '0, 3'd5, '0); // rewrite slot 0 while playing
        send_item(lps_pkg::OP_START, '0, '0, '0);  // restart while playing
        send_item(lps_pkg::OP_TICK, '0, '0, '0);   // new colour, no hold
        send_item(lps_pkg::OP_TICK, '0, '0, '0);   // pass used up, led off
        send_item(lps_pkg::OP_TICK, '0, '0, '0);   // stopped, nothing changes

        // random phases: each sets both registers, starts and plays on
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            len_pick  = $urandom_range(0, 9);
            pass_pick = $urandom_range(0, 9);
            case (len_pick)
                0:       len = '0;
                1:       len = lps_pkg::LENGTH_W'($urandom_range(lps_pkg::MAX_ENTRIES + 1, 31));
                default: len = lps_pkg::LENGTH_W'($urandom_range(1, lps_pkg::MAX_ENTRIES));
            endcase
            case (pass_pick)
                0:       passes = '0;
                1:       passes = '1;
                2:       passes = lps_pkg::PASS_W'($urandom);
                default: passes = lps_pkg::PASS_W'($urandom_range(1, 3));
            endcase
            // the extremes come first
            case (phase)
                0: begin len = '0;                                     passes = 8'd3; end
                1: begin len = '1;                                     passes = '1;   end
                2: begin len = lps_pkg::LENGTH_W'(lps_pkg::MAX_ENTRIES); passes = '0; end
                3: begin len = lps_pkg::LENGTH_W'(1);                  passes = '1;   end
                default: ;
            endcase
            reconfigure(len, passes);

            // one phase with a long sink hold-off that stalls the input side,
            // and a few with no idling at all
            if (phase == 3)
                hold_off_req = 1'b1;
            steady = (phase >= 6 && phase <= 8);

            send_item(lps_pkg::OP_START, lps_pkg::INDEX_W'($urandom),
                      lps_pkg::RGB_W'($urandom), lps_pkg::HOLD_IN_W'($urandom));
            for (int n = 1; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                idx  = lps_pkg::INDEX_W'($urandom);
                rgb  = lps_pkg::RGB_W'($urandom);
                hold = lps_pkg::HOLD_IN_W'($urandom);
                if (pick < 72)
                    op = lps_pkg::OP_TICK;
                else if (pick < 82)
                begin
                    op = lps_pkg::OP_LOAD;
                    // mostly short holds so patterns keep moving
                    if ($urandom_range(0, 39) != 0)
                        hold = lps_pkg::HOLD_IN_W'($urandom_range(0, 3));
                end
                else if (pick < 90)
                    op = lps_pkg::OP_START;
                else if (pick < 94)
                    op = OP_SPARE;
                else
                    op = lps_pkg::OP_TICK;
                send_item(op, idx, rgb, hold);
            end
        end

        @(negedge clk);
        item_ch.valid = 1'b0;
        steady = 1'b0;
        waited = 0;
        while (sb.led_drive_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (sb.led_drive_q.size() != 0)
        begin
            sb.mismatches++;
            $display("%0t ns: %0d result beats never arrived, expected 0 outstanding",
                     $time, sb.led_drive_q.size());
        end

        if (sb.mismatches == 0)
            $display("led_pattern_sequencer regression: pass");
        else
            $display("led_pattern_sequencer regression: fail");
        $finish;
    end

endmodule
